// ===== src/mks_pkg.sv =====
// Shared types, constants and key map of the keypad scanner.
package mks_pkg;

   localparam logic       CMD_SCAN = 1'b0;
   localparam logic       CMD_READ = 1'b1;

   localparam logic [1:0] PH_DRIVE   = 2'd0;
   localparam logic [1:0] PH_SAMPLE  = 2'd1;
   localparam logic [1:0] PH_CONFIRM = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   localparam int         ROWS            = 4;
   localparam int         KEY_W           = 7;
   localparam logic [3:0] COL_MASK        = 4'hF;
   localparam logic [7:0] SCAN_BASE_RESET = 8'hFF;

   typedef struct packed {
      logic       cmd;
      logic [3:0] column_sense;
   } mks_req_type;

   typedef struct packed {
      logic             scan_write;
      logic [7:0]       scan_drive;
      logic             key_present;
      logic [KEY_W-1:0] key_code;
   } mks_rsp_type;

   typedef struct packed {
      logic        valid;
      mks_req_type item;
   } mks_slot_type;

   localparam logic [KEY_W-1:0] KEY_CHARS [ROWS][4] = '{
      '{7'h30, 7'h41, 7'h42, 7'h46},
      '{7'h37, 7'h38, 7'h39, 7'h45},
      '{7'h34, 7'h35, 7'h36, 7'h44},
      '{7'h31, 7'h32, 7'h33, 7'h43}
   };

   function automatic logic [KEY_W-1:0] key_char(input logic [1:0] row,
                                                 input logic [3:0] cols);
      logic [KEY_W-1:0] code;
      priority if (!cols[0]) begin
         code = KEY_CHARS[row][0];
      end else if (!cols[1]) begin
         code = KEY_CHARS[row][1];
      end else if (!cols[2]) begin
         code = KEY_CHARS[row][2];
      end else if (!cols[3]) begin
         code = KEY_CHARS[row][3];
      end else begin
         code = '0;
      end
      return code;
   endfunction

endpackage

// ===== src/mks_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mks_front.sv =====
// Front end: two-entry request queue that takes commands from the input channel.
module mks_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  mks_pkg::mks_req_type req_data,
   output mks_pkg::mks_slot_type head,
   input  logic                 head_pop
);
   import mks_pkg::*;

   mks_req_type q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign req_full   = (count_ff == 2'd2);
   assign do_push    = req_push && !req_full;
   assign do_pop     = head_pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ===== src/mks_back.sv =====
// Back end: row debounce machines, key ring buffer and result register.
module mks_back #(
   parameter int KEY_FIFO_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mks_pkg::mks_slot_type head,
   output logic                  head_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output mks_pkg::mks_rsp_type  rsp_data
);
   import mks_pkg::*;

   localparam int IDX_W = $clog2(KEY_FIFO_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       iter_ff, iter_in;
   logic [3:0]       cols_ff, cols_in;
   logic [1:0]       row_pointer_ff, row_pointer_in;
   logic [1:0]       phase_ff [ROWS];
   logic [1:0]       phase_in [ROWS];
   logic [3:0]       sample_ff [ROWS];
   logic [3:0]       sample_in [ROWS];
   logic [KEY_W-1:0] pending_ff, pending_in;
   logic [IDX_W-1:0] wi_ff, wi_in, wi_next;
   logic [IDX_W-1:0] ri_ff, ri_in, ri_next;
   logic [7:0]       scan_base_ff, scan_base_in;
   logic             out_valid_ff, out_valid_in;
   mks_rsp_type      out_ff, out_in;

   logic             out_free;
   logic             ram_wr_en, ram_rd_en;
   logic [KEY_W-1:0] ram_rd_data;
   logic [1:0]       r;
   logic [7:0]       rowdrive;
   logic             stop, wr;
   logic [7:0]       drive;

   mks_ram #(
      .WIDTH(KEY_W),
      .DEPTH(KEY_FIFO_DEPTH)
   ) u_key_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wi_ff),
      .wr_data(pending_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ri_ff),
      .rd_data(ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign r         = row_pointer_ff;
   assign rowdrive  = scan_base_ff & ~(8'b1 << r);
   assign wi_next   = (wi_ff == IDX_W'(KEY_FIFO_DEPTH - 1)) ? '0 : wi_ff + 1'b1;
   assign ri_next   = (ri_ff == IDX_W'(KEY_FIFO_DEPTH - 1)) ? '0 : ri_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      iter_in        = iter_ff;
      cols_in        = cols_ff;
      row_pointer_in = row_pointer_ff;
      phase_in       = phase_ff;
      sample_in      = sample_ff;
      pending_in     = pending_ff;
      wi_in          = wi_ff;
      ri_in          = ri_ff;
      scan_base_in   = (csr_valid && csr_ready) ? csr_data : scan_base_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_in         = out_ff;
      head_pop       = 1'b0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      stop           = 1'b0;
      wr             = 1'b0;
      drive          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               head_pop = 1'b1;
               cols_in  = head.item.column_sense;
               iter_in  = 2'd0;
               if (head.item.cmd == CMD_READ) begin
                  if (wi_ff != ri_ff) begin
                     ram_rd_en = 1'b1;
                     ri_in     = ri_next;
                     state_in  = ST_READ;
                  end else begin
                     out_valid_in = 1'b1;
                     out_in       = '0;
                  end
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            unique case (phase_ff[r])
               PH_DRIVE: begin
                  wr          = 1'b1;
                  drive       = rowdrive;
                  phase_in[r] = PH_SAMPLE;
                  stop        = 1'b1;
               end
               PH_SAMPLE: begin
                  sample_in[r] = cols_ff;
                  if (cols_ff == COL_MASK) begin
                     phase_in[r] = PH_DRIVE;
                  end else begin
                     phase_in[r] = PH_CONFIRM;
                     stop        = 1'b1;
                  end
               end
               PH_CONFIRM: begin
                  if (cols_ff != sample_ff[r]) begin
                     phase_in[r] = PH_DRIVE;
                  end else begin
                     pending_in  = key_char(r, sample_ff[r]);
                     phase_in[r] = PH_RELEASE;
                     wr          = 1'b1;
                     drive       = rowdrive;
                     stop        = 1'b1;
                  end
               end
               default: begin
                  if (cols_ff == COL_MASK) begin
                     ram_wr_en   = 1'b1;
                     wi_in       = wi_next;
                     if (wi_next == ri_ff) begin
                        ri_in = ri_next;
                     end
                     phase_in[r] = PH_DRIVE;
                  end else begin
                     wr    = 1'b1;
                     drive = rowdrive;
                     stop  = 1'b1;
                  end
               end
            endcase
            if (stop || iter_ff == 2'd3) begin
               out_valid_in       = 1'b1;
               out_in.scan_write  = wr;
               out_in.scan_drive  = drive;
               out_in.key_present = 1'b0;
               out_in.key_code    = '0;
               state_in           = ST_IDLE;
            end else begin
               row_pointer_in = row_pointer_ff + 2'd1;
               iter_in        = iter_ff + 2'd1;
            end
         end
         ST_READ: begin
            out_valid_in       = 1'b1;
            out_in.scan_write  = 1'b0;
            out_in.scan_drive  = '0;
            out_in.key_present = 1'b1;
            out_in.key_code    = ram_rd_data;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         iter_ff        <= 2'd0;
         row_pointer_ff <= 2'd0;
         phase_ff       <= '{default: PH_DRIVE};
         pending_ff     <= '0;
         wi_ff          <= '0;
         ri_ff          <= '0;
         scan_base_ff   <= SCAN_BASE_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         iter_ff        <= iter_in;
         row_pointer_ff <= row_pointer_in;
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         wi_ff          <= wi_in;
         ri_ff          <= ri_in;
         scan_base_ff   <= scan_base_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff   <= cols_in;
      sample_ff <= sample_in;
      out_ff    <= out_in;
   end

endmodule

// ===== src/matrix_keypad_scanner_unit.sv =====
// Top level of the 4x4 keypad scanner with debounce and key buffer.
//
// Usage: push scan ticks (cmd 0, with the sampled columns) and key reads (cmd 1)
// into the req_ channel while req_full is low. Each command yields exactly one
// result on the rsp_ channel, in order; the oldest result sits on rsp_data while
// rsp_empty is low and leaves on pop. The csr_ channel writes the scan port base
// value and is always ready; write it only while no command is outstanding.
// A scan tick is popped from the two-entry request queue and then visits rows in
// turn, up to four; a read of a buffered key passes through the registered key
// RAM, an empty read is answered straight from idle. A new command is taken only
// once the previous one is finished and the result register is free.
// Reset clears the request queue, result register, row pointer, key buffer
// indexes and sets every row to its drive phase; scan base returns to 0xFF.
// When the receiver stalls, the finished result holds and the request queue
// keeps taking up to two commands before req_full rises.
module matrix_keypad_scanner_unit #(
   parameter int KEY_FIFO_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  mks_pkg::mks_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output mks_pkg::mks_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);
   import mks_pkg::*;

   mks_slot_type head;
   logic         head_pop;

   mks_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .head    (head),
      .head_pop(head_pop)
   );

   mks_back #(
      .KEY_FIFO_DEPTH(KEY_FIFO_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_idle_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.scan_write) |-> (rsp_data.scan_drive == 8'd0))
      else $error("scan_drive set without scan_write");

   a_key_is_read: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.key_present) |->
         (!rsp_data.scan_write && rsp_data.key_code != 7'd0))
      else $error("key result mixed with scan result or empty code");

   a_no_key_no_code: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.key_present) |-> (rsp_data.key_code == 7'd0))
      else $error("key_code set without key_present");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the keypad scanner: directed table, then random ticks and reads checked in order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mks_pkg::*;

   localparam int          IDLE_LIMIT  = 2000;
   localparam int          PHASE_COUNT = 7;
   localparam int          PHASE_ITEMS = 150;
   localparam int          TABLE_ROWS  = 24;
   localparam mks_rsp_type RSP_NONE    = '0;

   typedef struct packed {
      logic        typed;
      mks_req_type item;
      mks_rsp_type rsp;
   } table_row_type;

   localparam table_row_type DIRECTED [TABLE_ROWS] = '{
      '{1'b1, '{CMD_READ, 4'h0}, '{1'b0, 8'h00, 1'b0, 7'h00}},
      '{1'b1, '{CMD_SCAN, 4'hF}, '{1'b1, 8'hFE, 1'b0, 7'h00}},
      '{1'b1, '{CMD_SCAN, 4'h0}, '{1'b0, 8'h00, 1'b0, 7'h00}},
      '{1'b1, '{CMD_SCAN, 4'h0}, '{1'b1, 8'hFE, 1'b0, 7'h00}},
      '{1'b0, '{CMD_SCAN, 4'h7}, RSP_NONE},
      '{1'b1, '{CMD_SCAN, 4'hF}, '{1'b1, 8'hFD, 1'b0, 7'h00}},
      '{1'b1, '{CMD_READ, 4'hF}, '{1'b0, 8'h00, 1'b1, 7'h30}},
      '{1'b1, '{CMD_READ, 4'h5}, '{1'b0, 8'h00, 1'b0, 7'h00}},
      '{1'b0, '{CMD_SCAN, 4'h8}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hD}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hF}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'h7}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'h7}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hF}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hF}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hB}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hB}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hF}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hD}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hD}, RSP_NONE},
      '{1'b0, '{CMD_SCAN, 4'hF}, RSP_NONE},
      '{1'b1, '{CMD_READ, 4'hA}, '{1'b0, 8'h00, 1'b1, 7'h43}},
      '{1'b0, '{CMD_READ, 4'h0}, RSP_NONE},
      '{1'b0, '{CMD_READ, 4'hF}, RSP_NONE}
   };

   localparam logic [6:0] KEY_MAP [4][4] = '{
      '{7'h30, 7'h41, 7'h42, 7'h46},
      '{7'h37, 7'h38, 7'h39, 7'h45},
      '{7'h34, 7'h35, 7'h36, 7'h44},
      '{7'h31, 7'h32, 7'h33, 7'h43}
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   mks_req_type req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   mks_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data  = '0;

   // keypad state as seen by the predictor
   logic [7:0]  scan_base_copy = SCAN_BASE_RESET;
   logic [1:0]  row_ptr        = '0;
   logic [1:0]  row_state [4]  = '{PH_DRIVE, PH_DRIVE, PH_DRIVE, PH_DRIVE};
   logic [3:0]  row_cols  [4]  = '{4'h0, 4'h0, 4'h0, 4'h0};
   logic [6:0]  held_key       = '0;
   logic [6:0]  key_ring  [16];
   logic [3:0]  ring_wr        = '0;
   logic [3:0]  ring_rd        = '0;

   mks_rsp_type expected_rsps [$];
   int          mismatches  = 0;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   bit          no_idle     = 1'b0;
   int          press_left  = 0;
   int          release_left = 0;
   logic [3:0]  press_cols  = 4'hF;

   matrix_keypad_scanner_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [6:0] released_char(logic [1:0] row, logic [3:0] cols);
      for (int c = 0; c < 4; c++) begin
         if (!cols[c]) begin
            return KEY_MAP[row][c];
         end
      end
      return '0;
   endfunction

   function automatic void queue_key(logic [6:0] code);
      key_ring[ring_wr] = code;
      ring_wr = ring_wr + 4'd1;
      if (ring_wr == ring_rd) begin
         ring_rd = ring_rd + 4'd1;
      end
   endfunction

   function automatic mks_rsp_type keypad_step(mks_req_type it);
      mks_rsp_type res;
      logic [1:0]  row;
      logic [7:0]  drive;
      bit          halt;
      res  = '0;
      row  = row_ptr;
      halt = 1'b0;
      if (it.cmd == CMD_READ) begin
         if (ring_wr != ring_rd) begin
            res.key_present = 1'b1;
            res.key_code    = key_ring[ring_rd];
            ring_rd         = ring_rd + 4'd1;
         end
      end else begin
         for (int i = 0; i < 4 && !halt; i++) begin
            row   = row_ptr + 2'(i);
            drive = scan_base_copy & ~(8'd1 << row);
            case (row_state[row])
               PH_DRIVE: begin
                  res.scan_write = 1'b1;
                  res.scan_drive = drive;
                  row_state[row] = PH_SAMPLE;
                  halt           = 1'b1;
               end
               PH_SAMPLE: begin
                  row_cols[row] = it.column_sense;
                  if (it.column_sense == COL_MASK) begin
                     row_state[row] = PH_DRIVE;
                  end else begin
                     row_state[row] = PH_CONFIRM;
                     halt           = 1'b1;
                  end
               end
               PH_CONFIRM: begin
                  if (it.column_sense != row_cols[row]) begin
                     row_state[row] = PH_DRIVE;
                  end else begin
                     held_key       = released_char(row, row_cols[row]);
                     row_state[row] = PH_RELEASE;
                     res.scan_write = 1'b1;
                     res.scan_drive = drive;
                     halt           = 1'b1;
                  end
               end
               default: begin
                  if (it.column_sense == COL_MASK) begin
                     queue_key(held_key);
                     row_state[row] = PH_DRIVE;
                  end else begin
                     res.scan_write = 1'b1;
                     res.scan_drive = drive;
                     halt           = 1'b1;
                  end
               end
            endcase
         end
         row_ptr = row;
      end
      return res;
   endfunction

   // keys held for a few ticks then released, with some noise and reads mixed in
   function automatic mks_req_type next_keypad_item(int read_odds);
      mks_req_type it;
      it.cmd          = CMD_SCAN;
      it.column_sense = 4'(($urandom));
      if ($urandom_range(0, read_odds - 1) == 0) begin
         it.cmd = CMD_READ;
      end else if ($urandom_range(0, 11) != 0) begin
         if (press_left == 0 && release_left == 0) begin
            press_cols   = 4'($urandom_range(0, 14));
            press_left   = $urandom_range(2, 7);
            release_left = $urandom_range(1, 4);
         end
         if (press_left > 0) begin
            it.column_sense = press_cols;
            press_left--;
         end else begin
            it.column_sense = COL_MASK;
            release_left--;
         end
      end
      return it;
   endfunction

   task automatic send_item(mks_req_type it, bit typed, mks_rsp_type typed_rsp);
      mks_rsp_type predicted;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      predicted = keypad_step(it);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_scan_base(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      scan_base_copy = value;
      csr_valid <= 1'b0;
   endtask

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               automatic mks_rsp_type want = expected_rsps.pop_front();
               if ($isunknown(rsp_data)) begin
                  $display("%0t: unknown bits, expected %h, actual %h", $time, want, rsp_data);
                  mismatches++;
               end else begin
                  compare_field("scan_write", want.scan_write, rsp_data.scan_write);
                  compare_field("scan_drive", want.scan_drive, rsp_data.scan_drive);
                  compare_field("key_present", want.key_present, rsp_data.key_present);
                  compare_field("key_code", want.key_code, rsp_data.key_code);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 6);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [7:0] base_values [PHASE_COUNT];
      int         read_odds;
      base_values = '{8'h00, 8'hA5, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'h7E};
      base_values[4] = 8'($urandom_range(0, 255));
      base_values[5] = 8'($urandom_range(0, 255));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < TABLE_ROWS; n++) begin
         send_item(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].rsp);
      end
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         write_scan_base(base_values[p]);
         no_idle   = (p == 2) || (p == PHASE_COUNT - 1);
         read_odds = (p % 3 == 0) ? 40 : ((p % 3 == 1) ? 5 : 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(next_keypad_item(read_odds), 1'b0, RSP_NONE);
         end
      end
      drain_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
